/* src/offset_journal_buffer_assert.svh */
// Assertion macros used by the offset journal buffer datapath.
`ifndef OFFSET_JOURNAL_BUFFER_ASSERT_SVH
`define OFFSET_JOURNAL_BUFFER_ASSERT_SVH
`ifndef SYNTHESIS
// Condition that must hold at every clock edge outside reset.
`define OJB_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
// Consequence that must hold in the cycle after the antecedent.
`define OJB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define OJB_ASSERT(lbl, cond, msg)
`define OJB_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* src/ojb_pkg.sv */
// Shared types and constants of the offset journal buffer.
package ojb_pkg;

	localparam int STORE_DEPTH   = 4096;
	localparam int ADDR_BITS     = $clog2(STORE_DEPTH);
	localparam int READ_LIMIT    = 64;
	localparam int OFFSET_BITS   = 48;
	localparam int CAP_BITS      = 13;
	localparam int MAX_BITS      = 7;
	localparam int CNT_BITS      = $clog2(READ_LIMIT + 1);
	localparam int CFG_DATA_BITS = 48;
	localparam int CFG_IDX_BITS  = 1;

	localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(STORE_DEPTH);

	// Request codes carried by req_type.
	typedef enum logic [1:0] {
		REQ_APPEND  = 2'd0,
		REQ_READ    = 2'd1,
		REQ_DELIVER = 2'd2,
		REQ_ACK     = 2'd3
	} req_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_CAPACITY  = 1'b0,
		CFG_SEQ_LIMIT = 1'b1
	} cfg_idx_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic calc;
		logic decide;
		logic stream;
	} ojb_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic stream_req;
		logic stream_done;
	} ojb_stat_t;

endpackage

/* src/offset_journal_buffer.sv */
// Top level of the offset journal buffer: controller and datapath.
//
// A byte journal addressed by absolute stream offsets, kept in a 4096-entry store.
// Requests enter through start/busy: an item is taken at a clock edge with start high
// and busy low. req_type selects append byte, read, mark delivered or acknowledge.
// Results leave on result_strobe, one cycle each; the receiver cannot hold them off.
// Append, delivered and acknowledge give one result each, registered from the decision state;
// the block takes the next item only once it is back in idle.
// A valid read returns up to read_max bytes, one result a cycle, each from the registered
// read port; the block stays busy until the last byte is issued.
// The item rate is set by the calculation and decision states of the controller and,
// for reads, by the single registered read port of the byte store.
// Configuration is written through cfg_we, cfg_index and cfg_data, by the user only while idle;
// the block itself does not enforce it. Reset clears all offsets and marks, sets capacity to
// the store depth and the sequence limit to all ones; the store contents are undefined until
// written, and no clearing pass is made.
module offset_journal_buffer
	import ojb_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	input  logic [1:0]               req_type,
	input  logic [7:0]               data_byte,
	input  logic                     first_of_run,
	input  logic [OFFSET_BITS-1:0]   run_length,
	input  logic [OFFSET_BITS-1:0]   position,
	input  logic [MAX_BITS-1:0]      read_max,
	output logic                     result_strobe,
	output logic                     ok,
	output logic                     gap,
	output logic [OFFSET_BITS-1:0]   start_offset,
	output logic [7:0]               out_byte,
	output logic                     byte_valid,
	output logic                     last
);

	ojb_cmd_t  cmd;
	ojb_stat_t stat;

	// Sequencing of each item.
	ojb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// Offsets, store and results.
	ojb_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.req_type      (req_type),
		.data_byte     (data_byte),
		.first_of_run  (first_of_run),
		.run_length    (run_length),
		.position      (position),
		.read_max      (read_max),
		.result_strobe (result_strobe),
		.ok            (ok),
		.gap           (gap),
		.start_offset  (start_offset),
		.out_byte      (out_byte),
		.byte_valid    (byte_valid),
		.last          (last)
	);

endmodule

/* src/ojb_ctrl.sv */
// Controller state machine of the offset journal buffer.
module ojb_ctrl
	import ojb_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  ojb_stat_t stat,
	output ojb_cmd_t  cmd,
	output logic      busy
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_CALC   = 4'b0010,
		ST_DECIDE = 4'b0100,
		ST_READ   = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_next;

	// Next state: one item at a time, reads stay in ST_READ until the last byte is issued.
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE:   if (start) state_next = ST_CALC;
			ST_CALC:   state_next = ST_DECIDE;
			ST_DECIDE: state_next = stat.stream_req ? ST_READ : ST_IDLE;
			ST_READ:   if (stat.stream_done) state_next = ST_IDLE;
			default:   state_next = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Commands to the datapath follow the state directly.
	always_comb begin
		cmd.capture = (state_q == ST_IDLE) && start;
		cmd.calc    = (state_q == ST_CALC);
		cmd.decide  = (state_q == ST_DECIDE);
		cmd.stream  = (state_q == ST_READ);
	end

	assign busy = (state_q != ST_IDLE);

endmodule

/* src/ojb_dpath.sv */
// Datapath of the offset journal buffer: offsets, byte store and result registers.
`include "offset_journal_buffer_assert.svh"
module ojb_dpath
	import ojb_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  ojb_cmd_t                 cmd,
	output ojb_stat_t                stat,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	input  logic [1:0]               req_type,
	input  logic [7:0]               data_byte,
	input  logic                     first_of_run,
	input  logic [OFFSET_BITS-1:0]   run_length,
	input  logic [OFFSET_BITS-1:0]   position,
	input  logic [MAX_BITS-1:0]      read_max,
	output logic                     result_strobe,
	output logic                     ok,
	output logic                     gap,
	output logic [OFFSET_BITS-1:0]   start_offset,
	output logic [7:0]               out_byte,
	output logic                     byte_valid,
	output logic                     last
);

	// Journal state and configuration.
	logic [OFFSET_BITS-1:0] oldest_q, end_q, deliv_q, acked_q, limit_q;
	logic [CAP_BITS-1:0]    cap_q;
	logic                   run_acc_q;

	// Captured request.
	req_t                   req_q;
	logic [7:0]             data_q;
	logic                   first_q;
	logic [OFFSET_BITS-1:0] len_q, pos_q;
	logic [MAX_BITS-1:0]    max_q;

	// Compare results registered in the calculation cycle.
	logic [OFFSET_BITS:0]   room_q;
	logic [OFFSET_BITS-1:0] fill_q, avail_pos_q;
	logic pos_gt_end_q, pos_gt_deliv_q, pos_gt_ack_q, pos_gt_old_q, pos_lt_old_q;

	// Read streaming.
	logic [ADDR_BITS-1:0]   rd_addr_q;
	logic [CNT_BITS-1:0]    cnt_q;
	logic [7:0]             mem [STORE_DEPTH];
	logic [7:0]             rdata_q;

	// Result registers.
	logic                   strobe_q, res_ok_q, res_gap_q, res_bv_q, res_last_q;
	logic [OFFSET_BITS-1:0] res_start_q;

	// Decision logic.
	logic                   new_acc, acc, do_app, full, cap_zero, end_ge_lim, rd_bad, avail_big;
	logic [OFFSET_BITS-1:0] end_plus, rd_start, rd_avail;
	logic [CNT_BITS-1:0]    rd_count;
	logic                   mem_we;
	logic                   dec_ok, dec_gap;
	logic [OFFSET_BITS-1:0] dec_start;

	// Capture the request on acceptance; a zero run length counts as one.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q   <= req_t'(req_type);
			data_q  <= data_byte;
			first_q <= first_of_run;
			len_q   <= (run_length == '0) ? OFFSET_BITS'(1) : run_length;
			pos_q   <= position;
			max_q   <= read_max;
		end
	end

	// Calculation cycle: the wide subtractions and compares against the state.
	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			room_q         <= {1'b0, limit_q} - {1'b0, end_q};
			fill_q         <= end_q - oldest_q;
			avail_pos_q    <= end_q - pos_q;
			pos_gt_end_q   <= pos_q > end_q;
			pos_gt_deliv_q <= pos_q > deliv_q;
			pos_gt_ack_q   <= pos_q > acked_q;
			pos_gt_old_q   <= pos_q > oldest_q;
			pos_lt_old_q   <= pos_q < oldest_q;
		end
	end

	// Decision cycle logic.
	always_comb begin
		end_ge_lim = room_q[OFFSET_BITS] || (room_q[OFFSET_BITS-1:0] == '0);
		new_acc    = !room_q[OFFSET_BITS] && (len_q <= room_q[OFFSET_BITS-1:0]);
		acc        = first_q ? new_acc : run_acc_q;
		do_app     = acc && !end_ge_lim;
		cap_zero   = (cap_q == '0);
		full       = (fill_q[OFFSET_BITS-1:CAP_BITS] != '0) || (fill_q[CAP_BITS-1:0] >= cap_q);
		end_plus   = end_q + OFFSET_BITS'(1);
		mem_we     = cmd.decide && (req_q == REQ_APPEND) && do_app && !cap_zero;

		rd_bad     = pos_gt_end_q || (max_q == '0) || (max_q > MAX_BITS'(READ_LIMIT));
		rd_start   = pos_lt_old_q ? oldest_q : pos_q;
		rd_avail   = pos_lt_old_q ? fill_q : avail_pos_q;
		avail_big  = (rd_avail[OFFSET_BITS-1:CNT_BITS] != '0) ||
			(rd_avail[CNT_BITS-1:0] >= CNT_BITS'(max_q));
		rd_count   = avail_big ? CNT_BITS'(max_q) : rd_avail[CNT_BITS-1:0];

		stat.stream_req  = cmd.decide && (req_q == REQ_READ) && !rd_bad && (rd_count != '0);
		stat.stream_done = (cnt_q == CNT_BITS'(1));
	end

	// Fields of a single result produced in the decision cycle.
	always_comb begin
		dec_ok    = 1'b0;
		dec_gap   = 1'b0;
		dec_start = '0;
		unique case (req_q)
			REQ_APPEND:  dec_ok = do_app;
			REQ_READ: begin
				if (!rd_bad) begin
					dec_ok    = 1'b1;
					dec_gap   = pos_lt_old_q;
					dec_start = rd_start;
				end
			end
			REQ_DELIVER: dec_ok = !pos_gt_end_q;
			REQ_ACK:     dec_ok = !pos_gt_deliv_q;
			default:     dec_ok = 1'b0;
		endcase
	end

	// Journal state updates and configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q  <= '0;
			end_q     <= '0;
			deliv_q   <= '0;
			acked_q   <= '0;
			run_acc_q <= 1'b0;
			cap_q     <= CAP_RESET;
			limit_q   <= '1;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_CAPACITY: begin
						cap_q <= (cfg_data[CAP_BITS-1:0] > CAP_RESET) ?
							CAP_RESET : cfg_data[CAP_BITS-1:0];
					end
					CFG_SEQ_LIMIT: limit_q <= cfg_data[OFFSET_BITS-1:0];
					default: ;
				endcase
			end
			if (cmd.decide) begin
				unique case (req_q)
					REQ_APPEND: begin
						if (first_q) run_acc_q <= new_acc;
						if (do_app) begin
							end_q <= end_plus;
							if (cap_zero) begin
								oldest_q <= end_plus;
							end else if (full) begin
								oldest_q <= oldest_q + OFFSET_BITS'(1);
							end
						end
					end
					REQ_READ: ;
					REQ_DELIVER: begin
						if (!pos_gt_end_q && pos_gt_deliv_q) deliv_q <= pos_q;
					end
					REQ_ACK: begin
						if (!pos_gt_deliv_q && pos_gt_ack_q) begin
							acked_q <= pos_q;
							if (pos_gt_old_q) oldest_q <= pos_q;
						end
					end
					default: ;
				endcase
			end
		end
	end

	// Read address and byte counter.
	always_ff @(posedge clk) begin
		if (stat.stream_req) begin
			rd_addr_q <= rd_start[ADDR_BITS-1:0];
			cnt_q     <= rd_count;
		end else if (cmd.stream) begin
			rd_addr_q <= rd_addr_q + ADDR_BITS'(1);
			cnt_q     <= cnt_q - CNT_BITS'(1);
		end
	end

	// Byte store: one write port for appends, one registered read port for streaming.
	always_ff @(posedge clk) begin
		if (mem_we) mem[end_q[ADDR_BITS-1:0]] <= data_q;
		if (cmd.stream) rdata_q <= mem[rd_addr_q];
	end

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= (cmd.decide && !stat.stream_req) || cmd.stream;
		end
	end

	// Result fields; a stream keeps ok, gap and start from the decision cycle.
	always_ff @(posedge clk) begin
		if (cmd.decide) begin
			res_ok_q    <= dec_ok;
			res_gap_q   <= dec_gap;
			res_start_q <= dec_start;
			res_bv_q    <= 1'b0;
			res_last_q  <= 1'b1;
		end else if (cmd.stream) begin
			res_bv_q   <= 1'b1;
			res_last_q <= stat.stream_done;
		end
	end

	assign result_strobe = strobe_q;
	assign ok            = res_ok_q;
	assign gap           = res_gap_q;
	assign start_offset  = res_start_q;
	assign out_byte      = res_bv_q ? rdata_q : 8'd0;
	assign byte_valid    = res_bv_q;
	assign last          = res_last_q;

	// The marks keep their order behind the end of the journal.
	`OJB_ASSERT(a_mark_order, acked_q <= deliv_q && deliv_q <= end_q && oldest_q <= end_q, "offset marks out of order")
	// Every streaming cycle yields a byte result in the next cycle.
	`OJB_ASSERT_NEXT(a_stream_byte, cmd.stream, strobe_q && res_bv_q, "streamed byte missing")
	// A read's bytes follow one another without a hole until the last one.
	`OJB_ASSERT_NEXT(a_stream_gapless, strobe_q && !res_last_q, strobe_q, "hole in read stream")

endmodule

/* verif/tb_offset_journal_buffer.sv */
// Self-checking testbench of the offset journal buffer: directed and random requests.
`timescale 1ns / 100ps

module tb_offset_journal_buffer;
	import ojb_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int PHASE_ITEMS = 50;
	localparam int PHASE_COUNT = 8;
	localparam int TAIL_CYCLES = 8;
	localparam logic [OFFSET_BITS-1:0] ALL_ONES = '1;

	// One request item as presented on the input ports.
	typedef struct {
		req_t                   kind;
		logic [7:0]             data;
		logic                   first;
		logic [OFFSET_BITS-1:0] run_len;
		logic [OFFSET_BITS-1:0] pos;
		logic [MAX_BITS-1:0]    max;
	} journal_req_t;

	// One result item as it leaves the block.
	typedef struct {
		logic                   ok;
		logic                   gap;
		logic [OFFSET_BITS-1:0] start;
		logic [7:0]             data;
		logic                   valid;
		logic                   last;
	} journal_res_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start = 1'b0;
	logic                     busy;
	logic                     cfg_we = 1'b0;
	logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;
	logic [1:0]               req_type = '0;
	logic [7:0]               data_byte = '0;
	logic                     first_of_run = 1'b0;
	logic [OFFSET_BITS-1:0]   run_length = '0;
	logic [OFFSET_BITS-1:0]   position = '0;
	logic [MAX_BITS-1:0]      read_max = '0;
	logic                     result_strobe;
	logic                     ok;
	logic                     gap;
	logic [OFFSET_BITS-1:0]   start_offset;
	logic [7:0]               out_byte;
	logic                     byte_valid;
	logic                     last;

	offset_journal_buffer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req_type(req_type),
		.data_byte(data_byte),
		.first_of_run(first_of_run),
		.run_length(run_length),
		.position(position),
		.read_max(read_max),
		.result_strobe(result_strobe),
		.ok(ok),
		.gap(gap),
		.start_offset(start_offset),
		.out_byte(out_byte),
		.byte_valid(byte_valid),
		.last(last)
	);

	// Clock generation.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Journal state as predicted, starting from its reset values.
	logic [7:0]             jn_store [STORE_DEPTH];
	logic [OFFSET_BITS-1:0] jn_oldest = '0;
	logic [OFFSET_BITS-1:0] jn_end = '0;
	logic [OFFSET_BITS-1:0] jn_delivered = '0;
	logic [OFFSET_BITS-1:0] jn_acked = '0;
	logic                   jn_run_open = 1'b0;
	logic [CAP_BITS-1:0]    jn_cap = CAP_RESET;
	logic [OFFSET_BITS-1:0] jn_limit = ALL_ONES;

	journal_req_t req_backlog [$];
	journal_res_t due_results [$];
	journal_req_t cur;
	journal_res_t mon_want;
	int           idle_left = 0;
	bit           idle_en = 1'b1;
	int           fail_count = 0;
	int           cycle_count = 0;
	logic [OFFSET_BITS-1:0] gen_end;
	logic [OFFSET_BITS-1:0] gen_deliv;

	// Advance the predicted journal by one accepted item and queue its results.
	function automatic void journal_step(input journal_req_t rq);
		logic [OFFSET_BITS-1:0] len;
		logic [OFFSET_BITS-1:0] from;
		logic [OFFSET_BITS-1:0] avail;
		logic [OFFSET_BITS-1:0] count;
		logic [OFFSET_BITS-1:0] idx;
		journal_res_t r;
		r = '{ok: 1'b0, gap: 1'b0, start: '0, data: '0, valid: 1'b0, last: 1'b1};
		case (rq.kind)
			REQ_APPEND: begin
				// The first byte of a run decides the fate of the whole run.
				if (rq.first) begin
					len = (rq.run_len == '0) ? OFFSET_BITS'(1) : rq.run_len;
					jn_run_open = (jn_end <= jn_limit) && (len <= jn_limit - jn_end);
				end
				if (jn_run_open && jn_end < jn_limit) begin
					if (jn_cap == '0) begin
						jn_end = jn_end + 1'b1;
						jn_oldest = jn_end;
					end else begin
						if (jn_end - jn_oldest >= OFFSET_BITS'(jn_cap))
							jn_oldest = jn_oldest + 1'b1;
						jn_store[jn_end[ADDR_BITS-1:0]] = rq.data;
						jn_end = jn_end + 1'b1;
					end
					r.ok = 1'b1;
				end
				due_results.insert(due_results.size(), r);
			end
			REQ_READ: begin
				if (rq.pos > jn_end || rq.max == '0 || rq.max > READ_LIMIT) begin
					due_results.insert(due_results.size(), r);
				end else begin
					r.ok = 1'b1;
					r.gap = rq.pos < jn_oldest;
					from = r.gap ? jn_oldest : rq.pos;
					r.start = from;
					avail = jn_end - from;
					count = (OFFSET_BITS'(rq.max) < avail) ? OFFSET_BITS'(rq.max) : avail;
					if (count == '0) begin
						due_results.insert(due_results.size(), r);
					end else begin
						for (int i = 0; i < int'(count); i++) begin
							idx = from + OFFSET_BITS'(i);
							r.data = jn_store[idx[ADDR_BITS-1:0]];
							r.valid = 1'b1;
							r.last = (i + 1 == int'(count));
							due_results.insert(due_results.size(), r);
						end
					end
				end
			end
			REQ_DELIVER: begin
				if (rq.pos <= jn_end) begin
					r.ok = 1'b1;
					if (rq.pos > jn_delivered)
						jn_delivered = rq.pos;
				end
				due_results.insert(due_results.size(), r);
			end
			default: begin
				if (rq.pos <= jn_delivered) begin
					r.ok = 1'b1;
					if (rq.pos > jn_acked) begin
						jn_acked = rq.pos;
						if (jn_oldest < rq.pos)
							jn_oldest = rq.pos;
					end
				end
				due_results.insert(due_results.size(), r);
			end
		endcase
	endfunction

	// Driver: presents backlog items and holds each until it is taken.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				journal_step(cur);
			if (!start || !busy) begin
				if (idle_left > 0) begin
					idle_left--;
					start <= 1'b0;
				end else if (req_backlog.size() > 0) begin
					cur = req_backlog[0];
					req_backlog.delete(0);
					req_type <= cur.kind;
					data_byte <= cur.data;
					first_of_run <= cur.first;
					run_length <= cur.run_len;
					position <= cur.pos;
					read_max <= cur.max;
					start <= 1'b1;
					if (idle_en && $urandom_range(0, 5) == 0)
						idle_left = $urandom_range(1, 19);
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	function automatic void check_field(input string name, input logic [OFFSET_BITS-1:0] want,
			input logic [OFFSET_BITS-1:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
			fail_count++;
		end
	endfunction

	// Monitor: every strobed result is matched against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && result_strobe) begin
			if (due_results.size() == 0) begin
				$error("result item with no prediction waiting");
				fail_count++;
			end else begin
				mon_want = due_results[0];
				due_results.delete(0);
				check_field("ok", mon_want.ok, ok);
				check_field("gap", mon_want.gap, gap);
				check_field("start_offset", mon_want.start, start_offset);
				check_field("out_byte", mon_want.data, out_byte);
				check_field("byte_valid", mon_want.valid, byte_valid);
				check_field("last", mon_want.last, last);
			end
		end
	end

	// Watchdog on the length of the run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("offset_journal_buffer: mismatch");
			$finish;
		end
	end

	function automatic logic [OFFSET_BITS-1:0] rand_offset();
		logic [63:0] w;
		w = {$urandom(), $urandom()};
		return w[OFFSET_BITS-1:0];
	endfunction

	// An item with every field random; callers override what matters.
	function automatic journal_req_t noise_req();
		journal_req_t rq;
		rq.kind = req_t'($urandom_range(0, 3));
		rq.data = 8'($urandom());
		rq.first = 1'($urandom());
		rq.run_len = rand_offset();
		rq.pos = rand_offset();
		rq.max = MAX_BITS'($urandom());
		return rq;
	endfunction

	function automatic journal_req_t mk_req(input req_t kind, input logic [7:0] data,
			input logic first, input logic [OFFSET_BITS-1:0] run_len,
			input logic [OFFSET_BITS-1:0] pos, input logic [MAX_BITS-1:0] max);
		journal_req_t rq;
		rq.kind = kind;
		rq.data = data;
		rq.first = first;
		rq.run_len = run_len;
		rq.pos = pos;
		rq.max = max;
		return rq;
	endfunction

	// Offset at or below the estimated end, never below zero.
	function automatic logic [OFFSET_BITS-1:0] below(input logic [OFFSET_BITS-1:0] top,
			input int span);
		int r;
		r = $urandom_range(0, span);
		return (top > OFFSET_BITS'(r)) ? top - OFFSET_BITS'(r) : '0;
	endfunction

	// Queue an append run, mostly well formed, and return its item count.
	function automatic int gen_run();
		int len;
		logic [OFFSET_BITS-1:0] claim;
		bit headless;
		journal_req_t rq;
		len = $urandom_range(1, 40);
		case ($urandom_range(0, 19))
			0, 1: claim = OFFSET_BITS'($urandom_range(1, len));
			2: claim = '0;
			3: claim = rand_offset();
			4: claim = ALL_ONES;
			default: claim = OFFSET_BITS'(len);
		endcase
		headless = ($urandom_range(0, 11) == 0);
		for (int i = 0; i < len; i++) begin
			rq = noise_req();
			rq.kind = REQ_APPEND;
			rq.first = (i == 0) && !headless;
			if (i == 0)
				rq.run_len = claim;
			req_backlog.insert(req_backlog.size(), rq);
		end
		gen_end = gen_end + OFFSET_BITS'(len);
		return len;
	endfunction

	function automatic journal_req_t gen_read();
		journal_req_t rq;
		rq = noise_req();
		rq.kind = REQ_READ;
		case ($urandom_range(0, 19))
			0, 1, 2: rq.pos = gen_end + OFFSET_BITS'($urandom_range(0, 1));
			3, 4: rq.pos = '0;
			5, 6: rq.pos = rand_offset();
			7: rq.pos = ALL_ONES;
			default: rq.pos = below(gen_end, 100);
		endcase
		case ($urandom_range(0, 9))
			0: rq.max = '0;
			1: rq.max = MAX_BITS'($urandom_range(READ_LIMIT + 1, 127));
			2: rq.max = MAX_BITS'(READ_LIMIT);
			default: rq.max = MAX_BITS'($urandom_range(1, READ_LIMIT));
		endcase
		return rq;
	endfunction

	function automatic journal_req_t gen_mark(input req_t kind);
		journal_req_t rq;
		rq = noise_req();
		rq.kind = kind;
		case ($urandom_range(0, 9))
			0: rq.pos = rand_offset();
			1: rq.pos = gen_end + OFFSET_BITS'($urandom_range(1, 3));
			default: rq.pos = (kind == REQ_DELIVER) ? below(gen_end, 20) :
				below(gen_deliv, 20);
		endcase
		if (kind == REQ_DELIVER && rq.pos <= gen_end && rq.pos > gen_deliv)
			gen_deliv = rq.pos;
		return rq;
	endfunction

	// Register write on the configuration port, mirrored in the prediction.
	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_BITS-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		if (idx == CFG_CAPACITY)
			jn_cap = (value[CAP_BITS-1:0] > STORE_DEPTH) ? CAP_RESET : value[CAP_BITS-1:0];
		else
			jn_limit = value[OFFSET_BITS-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_config(input logic [CAP_BITS-1:0] cap, input logic [OFFSET_BITS-1:0] lim);
		logic [CFG_DATA_BITS-1:0] cap_word;
		cap_word = rand_offset();
		cap_word[CAP_BITS-1:0] = cap;
		write_reg(CFG_CAPACITY, cap_word);
		write_reg(CFG_SEQ_LIMIT, lim);
	endtask

	// Wait until every item is taken and every result has arrived, then settle.
	task automatic drain();
		while (req_backlog.size() != 0 || start || due_results.size() != 0 || busy)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// One random phase: a setting of both registers and a mix of requests.
	task automatic run_phase(input int p);
		int made;
		int pick;
		case (p)
			0: set_config(CAP_BITS'(1), ALL_ONES);
			1: set_config('0, ALL_ONES);
			2: set_config('1, jn_end + OFFSET_BITS'($urandom_range(10, 60)));
			3: set_config(CAP_BITS'($urandom_range(2, 40)), ALL_ONES);
			4: set_config(CAP_RESET, '0);
			5: set_config(CAP_BITS'($urandom_range(1, 16)),
				jn_end + OFFSET_BITS'($urandom_range(0, 30)));
			6: set_config(CAP_BITS'($urandom_range(0, 8191)), rand_offset());
			default: set_config(CAP_RESET, ALL_ONES);
		endcase
		idle_en = (p == PHASE_COUNT - 1) ? 1'b0 : ((p % 2 == 0) || ($urandom_range(0, 1) == 1));
		gen_end = jn_end;
		gen_deliv = jn_delivered;
		made = 0;
		while (made < PHASE_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				made += gen_run();
			end else if (pick < 75) begin
				req_backlog.insert(req_backlog.size(), gen_read());
				made++;
			end else if (pick < 85) begin
				req_backlog.insert(req_backlog.size(), gen_mark(REQ_DELIVER));
				made++;
			end else if (pick < 95) begin
				req_backlog.insert(req_backlog.size(), gen_mark(REQ_ACK));
				made++;
			end else begin
				req_backlog.insert(req_backlog.size(), noise_req());
				made++;
			end
		end
		drain();
	endtask

	// Stimulus sequence: reset, directed checks, then random phases.
	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Empty journal, stray byte, run length of zero and a short run.
		req_backlog.insert(req_backlog.size(), mk_req(REQ_READ, 8'h00, 1'b0, '0, '0, 7'd1));
		req_backlog.insert(req_backlog.size(), mk_req(REQ_APPEND, 8'h3C, 1'b0, '0, '0, '0));
		req_backlog.insert(req_backlog.size(), mk_req(REQ_APPEND, 8'h00, 1'b1, '0, '0, '0));
		req_backlog.insert(req_backlog.size(),
			mk_req(REQ_APPEND, 8'hFF, 1'b1, 48'd3, ALL_ONES, '1));
		req_backlog.insert(req_backlog.size(),
			mk_req(REQ_APPEND, 8'hA5, 1'b0, ALL_ONES, '0, '0));
		req_backlog.insert(req_backlog.size(), mk_req(REQ_APPEND, 8'h5A, 1'b0, '0, '0, '0));
		// Full read, partial read and each kind of invalid read.
		req_backlog.insert(req_backlog.size(),
			mk_req(REQ_READ, 8'h00, 1'b0, '0, 48'd0, 7'd64));
		req_backlog.insert(req_backlog.size(), mk_req(REQ_READ, 8'h00, 1'b0, '0, 48'd1, 7'd2));
		req_backlog.insert(req_backlog.size(), mk_req(REQ_READ, 8'h00, 1'b0, '0, 48'd0, 7'd0));
		req_backlog.insert(req_backlog.size(),
			mk_req(REQ_READ, 8'h00, 1'b0, '0, 48'd0, 7'd65));
		req_backlog.insert(req_backlog.size(),
			mk_req(REQ_READ, 8'hFF, 1'b1, ALL_ONES, 48'd0, 7'd127));
		req_backlog.insert(req_backlog.size(), mk_req(REQ_READ, 8'h00, 1'b0, '0, 48'd5, 7'd1));
		req_backlog.insert(req_backlog.size(),
			mk_req(REQ_READ, 8'h00, 1'b0, '0, 48'd4, 7'd10));
		// Delivered beyond end, rising and falling; acknowledge cases.
		req_backlog.insert(req_backlog.size(), mk_req(REQ_DELIVER, 8'h00, 1'b0, '0, 48'd5, '0));
		req_backlog.insert(req_backlog.size(), mk_req(REQ_DELIVER, 8'h00, 1'b0, '0, 48'd3, '0));
		req_backlog.insert(req_backlog.size(), mk_req(REQ_DELIVER, 8'h00, 1'b0, '0, 48'd2, '0));
		req_backlog.insert(req_backlog.size(), mk_req(REQ_ACK, 8'h00, 1'b0, '0, 48'd4, '0));
		req_backlog.insert(req_backlog.size(), mk_req(REQ_ACK, 8'h00, 1'b0, '0, 48'd2, '0));
		req_backlog.insert(req_backlog.size(), mk_req(REQ_ACK, 8'h00, 1'b0, '0, 48'd1, '0));
		// A read from before the retained start reports a gap.
		req_backlog.insert(req_backlog.size(),
			mk_req(REQ_READ, 8'h00, 1'b0, '0, 48'd0, 7'd64));
		// A run too long for the limit, and a byte that follows the rejection.
		req_backlog.insert(req_backlog.size(),
			mk_req(REQ_APPEND, 8'h11, 1'b1, ALL_ONES, '0, '0));
		req_backlog.insert(req_backlog.size(), mk_req(REQ_APPEND, 8'h22, 1'b0, '0, '0, '0));
		req_backlog.insert(req_backlog.size(),
			mk_req(REQ_READ, 8'h00, 1'b0, '0, ALL_ONES, 7'd64));
		req_backlog.insert(req_backlog.size(),
			mk_req(REQ_DELIVER, 8'h00, 1'b0, '0, ALL_ONES, '0));
		drain();

		for (int p = 0; p < PHASE_COUNT; p++)
			run_phase(p);

		if (fail_count == 0)
			$display("offset_journal_buffer: match");
		else
			$display("offset_journal_buffer: mismatch");
		$finish;
	end

endmodule
